>>> rtl/wsg_pkg.sv
// Package for the wavetable sound generator: widths, command codes, channel layout.
// No dependencies.
package wsg_pkg;
    localparam int RamBytesDef = 128;
    localparam int NumVoicesDef = 8;
    localparam logic [1:0] CMD_WRITE_DATA = 2'd0;
    localparam logic [1:0] CMD_WRITE_ADDR = 2'd1;
    localparam logic [1:0] CMD_READ_DATA  = 2'd2;
    localparam logic [1:0] CMD_TICK       = 2'd3;
    localparam logic [19:0] LEVEL_SCALE = 20'd576716;
    localparam logic [6:0] CHAN_BASE = 7'h40;
    localparam logic [6:0] CTRL_ADDR = 7'h7F;
endpackage

>>> rtl/wavetable_sound_generator.sv
// Wavetable sound generator top level: sound RAM, sequencer, channel state.
// Depends on wsg_pkg and wsg_mod_unit.
// A tick visits channels one after another: an inactive channel is skipped, a running
// countdown is decremented, and an expired one reloads through the serial modulo;
// all RAM reads go through the single read port.
// Throughput: one item at a time; s_axis_tready is low while an item is in work
// or its result waits. Reset: synchronous aresetn clears RAM (clearing pass, not ready
// meanwhile), pointer, channel state.
module wavetable_sound_generator
    import wsg_pkg::*;
#(
    parameter int RAM_BYTES = RamBytesDef,
    parameter int NUM_VOICES = NumVoicesDef
)(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [1:0] command, [9:2] data
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // [7:0] read_data, [21:8] mix_sample
);
    localparam int AW = $clog2(RAM_BYTES);
    localparam logic [2:0] FloorCh = 3'(8 - NUM_VOICES);

    localparam logic [4:0] S_CLEAR = 5'd0,  S_IDLE = 5'd1,  S_RD = 5'd2,  S_RDW = 5'd3,
                           S_CTL = 5'd4,    S_HI = 5'd5,    S_VOL = 5'd6, S_CHK = 5'd7,
                           S_F0 = 5'd8,     S_F1 = 5'd9,    S_F2 = 5'd10, S_MOD = 5'd11,
                           S_WA = 5'd12,    S_NIB = 5'd13,  S_NIBW = 5'd14, S_MUL = 5'd15,
                           S_SCL = 5'd16,   S_ACC = 5'd17,  S_OUT = 5'd18, S_NEXT = 5'd19;

    logic [7:0] ram [RAM_BYTES];
    logic [7:0] rdata_reg;
    logic [AW-1:0] raddr;
    logic       we;
    logic [AW-1:0] waddr;
    logic [7:0] wdata;

    logic [4:0]  state_reg, state_next;
    logic [AW-1:0] ptr_reg, ptr_next;
    logic        step_reg, step_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic [1:0]  cmd_reg, cmd_next;
    logic [7:0]  dat_reg, dat_next;
    logic [25:0] phase_reg [8];
    logic [6:0]  cd_reg [8];
    logic [10:0] lvl_reg [8];
    logic [2:0]  ch_reg, ch_next;
    logic [2:0]  n_reg, n_next;
    logic [7:0]  hi_reg, hi_next;
    logic [3:0]  vol_reg, vol_next;
    logic [17:0] freq_reg, freq_next;
    logic [7:0]  pos_reg, pos_next;
    logic [7:0]  prod_reg, prod_next;
    logic [27:0] scl_reg, scl_next;
    logic [13:0] sum_reg, sum_next;
    logic [7:0]  ord_reg, ord_next;
    logic        mvalid_reg, mvalid_next;
    logic        ph_we, cd_we, lvl_we;
    logic [25:0] ph_wd;
    logic [6:0]  cd_wd;
    logic [10:0] lvl_wd;
    logic        mod_start, mod_done;
    logic [25:0] mod_res;
    logic [6:0]  base;

    assign base = CHAN_BASE + {1'b0, ch_reg, 3'd0};

    wsg_mod_unit u_mod (
        .aclk(aclk), .aresetn(aresetn), .start(mod_start),
        .dividend({1'b0, phase_reg[ch_reg]} + 27'(freq_reg)),
        .len(9'd256 - {1'b0, hi_reg & 8'hFC}),
        .done(mod_done), .result(mod_res)
    );

    always_ff @(posedge aclk) begin
        if (we) ram[waddr] <= wdata;
        rdata_reg <= ram[raddr];
    end

    always_comb begin
        state_next = state_reg; ptr_next = ptr_reg; step_next = step_reg;
        clr_next = clr_reg; cmd_next = cmd_reg; dat_next = dat_reg;
        ch_next = ch_reg; n_next = n_reg; hi_next = hi_reg; vol_next = vol_reg;
        freq_next = freq_reg; pos_next = pos_reg; prod_next = prod_reg;
        scl_next = scl_reg; sum_next = sum_reg; ord_next = ord_reg;
        mvalid_next = mvalid_reg;
        raddr = ptr_reg; we = 1'b0; waddr = ptr_reg; wdata = dat_reg;
        ph_we = 1'b0; cd_we = 1'b0; lvl_we = 1'b0;
        ph_wd = mod_res; cd_wd = '0; lvl_wd = scl_reg[26:16];
        mod_start = 1'b0;
        if (mvalid_reg && m_axis_tready) mvalid_next = 1'b0;
        unique case (state_reg)
            S_CLEAR: begin
                we = 1'b1; waddr = clr_reg; wdata = '0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == AW'(RAM_BYTES - 1)) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (s_axis_tvalid && !mvalid_reg) begin
                    cmd_next = s_axis_tdata[1:0];
                    dat_next = s_axis_tdata[9:2];
                    ord_next = '0; sum_next = '0;
                    unique case (s_axis_tdata[1:0])
                        CMD_WRITE_DATA: begin
                            we = 1'b1; wdata = s_axis_tdata[9:2];
                            ptr_next = ptr_reg + AW'(step_reg);
                            state_next = S_OUT;
                        end
                        CMD_WRITE_ADDR: begin
                            ptr_next = s_axis_tdata[AW+1:2];
                            step_next = s_axis_tdata[9];
                            state_next = S_OUT;
                        end
                        CMD_READ_DATA: state_next = S_RD;
                        CMD_TICK: begin
                            raddr = CTRL_ADDR; state_next = S_CTL;
                        end
                        default: state_next = S_OUT;
                    endcase
                end
            end
            S_RD: state_next = S_RDW;
            S_RDW: begin
                ord_next = rdata_reg;
                ptr_next = ptr_reg + AW'(step_reg);
                state_next = S_OUT;
            end
            S_CTL: begin
                n_next = rdata_reg[6:4];
                ch_next = 3'd7;
                raddr = CHAN_BASE + 7'd60;
                state_next = S_HI;
            end
            S_HI: begin
                hi_next = rdata_reg;
                raddr = base + 7'd7;
                state_next = S_VOL;
            end
            S_VOL: begin
                vol_next = rdata_reg[3:0];
                state_next = S_CHK;
            end
            S_CHK: begin
                if ((hi_reg & 8'hE0) == 8'd0 || vol_reg == 4'd0) begin
                    state_next = S_NEXT;
                end else if (cd_reg[ch_reg] != 7'd0) begin
                    cd_wd = cd_reg[ch_reg] - 7'd1; cd_we = 1'b1;
                    state_next = S_ACC;
                end else begin
                    raddr = base; state_next = S_F0;
                end
            end
            S_F0: begin
                freq_next = {hi_reg[1:0], 8'd0, rdata_reg};
                raddr = base + 7'd2; state_next = S_F1;
            end
            S_F1: begin
                freq_next[15:8] = rdata_reg;
                raddr = base + 7'd6; state_next = S_F2;
            end
            S_F2: begin
                pos_next = rdata_reg;
                mod_start = 1'b1;
                state_next = S_MOD;
            end
            S_MOD: begin
                if (mod_done) begin
                    ph_we = 1'b1;
                    cd_we = 1'b1; cd_wd = 7'(({4'd0, n_reg} + 7'd1) * 7'd15 - 7'd1);
                    state_next = S_WA;
                end
            end
            S_WA: begin
                pos_next = phase_reg[ch_reg][24:17] + pos_reg;
                state_next = S_NIB;
            end
            S_NIB: begin
                raddr = pos_reg[7:1]; state_next = S_NIBW;
            end
            S_NIBW: begin
                raddr = pos_reg[7:1]; state_next = S_MUL;
            end
            S_MUL: begin
                prod_next = (pos_reg[0] ? rdata_reg[7:4] : rdata_reg[3:0]) * vol_reg;
                state_next = S_SCL;
            end
            S_SCL: begin
                scl_next = prod_reg * LEVEL_SCALE;
                state_next = S_ACC;
                lvl_we = 1'b0;
            end
            S_ACC: state_next = S_NEXT;
            S_NEXT: begin
                sum_next = sum_reg + 14'(lvl_reg[ch_reg]);
                if ((hi_reg & 8'hE0) == 8'd0 || vol_reg == 4'd0)
                    sum_next = sum_reg;
                if (ch_reg == 3'd7 - n_reg || ch_reg == FloorCh) begin
                    state_next = S_OUT;
                end else begin
                    ch_next = ch_reg - 3'd1;
                    raddr = CHAN_BASE + {1'b0, ch_reg - 3'd1, 3'd4};
                    state_next = S_HI;
                end
            end
            S_OUT: begin
                mvalid_next = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // level latches in the cycle after the scaling product is registered
    logic lvl_pend_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR; clr_reg <= '0; ptr_reg <= '0; step_reg <= 1'b0;
            mvalid_reg <= 1'b0; lvl_pend_reg <= 1'b0;
            for (int i = 0; i < 8; i++) begin
                phase_reg[i] <= '0; cd_reg[i] <= '0; lvl_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next; clr_reg <= clr_next; ptr_reg <= ptr_next;
            step_reg <= step_next; mvalid_reg <= mvalid_next;
            lvl_pend_reg <= (state_reg == S_SCL);
            if (ph_we) phase_reg[ch_reg] <= ph_wd;
            if (cd_we) cd_reg[ch_reg] <= cd_wd;
            if (lvl_pend_reg || lvl_we) lvl_reg[ch_reg] <= lvl_wd;
        end
        cmd_reg <= cmd_next; dat_reg <= dat_next; ch_reg <= ch_next; n_reg <= n_next;
        hi_reg <= hi_next; vol_reg <= vol_next; freq_reg <= freq_next; pos_reg <= pos_next;
        prod_reg <= prod_next; scl_reg <= scl_next; sum_reg <= sum_next; ord_reg <= ord_next;
    end

    assign s_axis_tready = (state_reg == S_IDLE) && !mvalid_reg;
    assign m_axis_tvalid = mvalid_reg;
    assign m_axis_tdata = {2'd0, (cmd_reg == CMD_TICK) ? sum_reg : 14'd0,
                           (cmd_reg == CMD_READ_DATA) ? ord_reg : 8'd0};
endmodule

>>> rtl/wsg_mod_unit.sv
// Bit-serial modulo unit: reduces a 27-bit sum modulo (len << 17), one bit per cycle.
// Depends on wsg_pkg.
module wsg_mod_unit
    import wsg_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [26:0] dividend,
    input  logic [8:0]  len,
    output logic        done,
    output logic [25:0] result
);
    logic [26:0] rem_reg, rem_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [35:0] dsh;
    logic [35:0] rem_w;

    always_comb begin
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done = 1'b0;
        rem_w = {9'd0, rem_reg};
        dsh = ({27'd0, len} << 17) << cnt_reg;
        if (start) begin
            rem_next = dividend;
            cnt_next = 5'd9;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (rem_w >= dsh) rem_next = rem_reg - dsh[26:0];
            if (cnt_reg == 5'd0) begin
                busy_next = 1'b0;
                done = 1'b1;
                if (rem_w >= dsh) rem_w = rem_w - dsh;
            end else begin
                cnt_next = cnt_reg - 5'd1;
            end
        end
    end
    assign result = rem_w[25:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg <= cnt_next;
        end
        rem_reg <= rem_next;
    end
endmodule

>>> rtl/wsg_checker.sv
// Port-level checker for the wavetable sound generator, bound to the top level.
// Depends on wsg_pkg.
module wsg_checker
    import wsg_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped");
    a_one: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("accepted two items back to back");
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("ready while result pending");
    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tdata[23:22] == 2'd0)
        else $error("pad bits set");
endmodule

bind wavetable_sound_generator wsg_checker u_chk (.*);
